// ----- hdl/zmb_pkg.sv -----
package zmb_pkg;

   // Bits per coordinate; codes are twice as wide.
   localparam int COORD_BITS = 32;
   localparam int CODE_BITS  = 64;
   localparam int TOTAL_BITS = 2 * COORD_BITS;
   localparam int POS_BITS   = $clog2(CODE_BITS);

   // Only the low TOTAL_BITS bits of a code take part.
   localparam logic [CODE_BITS-1:0] WIDTH_MASK = {CODE_BITS{1'b1}} >> (CODE_BITS - TOTAL_BITS);

   // Decision codes {probe bit, min bit, max bit}
   localparam logic [2:0] SEL_000 = 3'b000;
   localparam logic [2:0] SEL_001 = 3'b001;
   localparam logic [2:0] SEL_010 = 3'b010;
   localparam logic [2:0] SEL_011 = 3'b011;
   localparam logic [2:0] SEL_100 = 3'b100;
   localparam logic [2:0] SEL_101 = 3'b101;
   localparam logic [2:0] SEL_110 = 3'b110;
   localparam logic [2:0] SEL_111 = 3'b111;

   typedef struct packed {
      logic [CODE_BITS-1:0] probe_code;
      logic [CODE_BITS-1:0] box_min_code;
      logic [CODE_BITS-1:0] box_max_code;
   } req_item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] lit_max;
      logic [CODE_BITS-1:0] big_min;
      logic                 corner_error;
   } rsp_item_type;

   // Search state handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 done;
      logic                 err;
      logic [CODE_BITS-1:0] probe;
      logic [CODE_BITS-1:0] zmin;
      logic [CODE_BITS-1:0] zmax;
      logic [CODE_BITS-1:0] lit;
      logic [CODE_BITS-1:0] big;
   } state_type;

   // Bits of the same dimension as pos, at pos and below
   function automatic logic [CODE_BITS-1:0] dim_mask(input logic [POS_BITS-1:0] pos);
      logic [CODE_BITS-1:0] m;
      m = '0;
      for (int j = 0; j < CODE_BITS; j++) begin
         m[j] = (POS_BITS'(j) <= pos) && (1'(j) == pos[0]);
      end
      return m;
   endfunction

endpackage

// ----- hdl/zmb_cell.sv -----
module zmb_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic [zmb_pkg::POS_BITS-1:0] bit_pos,
   input  zmb_pkg::state_type           state_in,
   output zmb_pkg::state_type           state_out
);

   zmb_pkg::state_type                   state_ff;
   zmb_pkg::state_type                   state_in_nx;
   logic [zmb_pkg::CODE_BITS-1:0]        mask;
   logic [zmb_pkg::CODE_BITS-1:0]        top_bit;
   logic [zmb_pkg::CODE_BITS-1:0]        load_hi;
   logic [zmb_pkg::CODE_BITS-1:0]        load_lo;
   logic [2:0]                           sel;

   assign mask    = zmb_pkg::dim_mask(bit_pos);
   assign top_bit = zmb_pkg::CODE_BITS'(1) << bit_pos;
   // Patterns 1000... and 0111... for this dimension from bit_pos down
   assign load_hi = top_bit;
   assign load_lo = mask & ~top_bit;
   assign sel     = {state_in.probe[bit_pos], state_in.zmin[bit_pos], state_in.zmax[bit_pos]};

   // One step of the decision table
   always_comb begin
      state_in_nx = state_in;
      if (!state_in.done) begin
         case (sel) inside
            zmb_pkg::SEL_001: begin
               state_in_nx.big  = (state_in.zmin & ~mask) | load_hi;
               state_in_nx.zmax = (state_in.zmax & ~mask) | load_lo;
            end
            zmb_pkg::SEL_010, zmb_pkg::SEL_110: begin
               state_in_nx.err = 1'b1;
            end
            zmb_pkg::SEL_011: begin
               state_in_nx.big  = state_in.zmin;
               state_in_nx.done = 1'b1;
            end
            zmb_pkg::SEL_100: begin
               state_in_nx.lit  = state_in.zmax;
               state_in_nx.done = 1'b1;
            end
            zmb_pkg::SEL_101: begin
               state_in_nx.lit  = (state_in.zmax & ~mask) | load_lo;
               state_in_nx.zmin = (state_in.zmin & ~mask) | load_hi;
            end
            default: begin
            end
         endcase
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else if (enable) begin
         state_ff <= state_in_nx;
      end
   end

   assign state_out = state_ff;

endmodule

// ----- hdl/zorder_bigmin_litmax_top.sv -----
// BIGMIN/LITMAX search on 2-D Morton codes (x in even bits, y in odd bits).
// A row of TOTAL_BITS cells (64 with 32-bit coordinates) scans one code bit
// each, most significant first; an item passes through one register per cell
// and then the output register, and a new item is accepted every cycle while
// rsp_stall is low. lit_max and big_min are zero when never set; corner_error
// flags a min bit above a max bit.
module zorder_bigmin_litmax_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  zmb_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output zmb_pkg::rsp_item_type rsp_item
);

   zmb_pkg::state_type    chain [zmb_pkg::TOTAL_BITS+1];
   logic                  out_ready;
   logic                  advance;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   zmb_pkg::rsp_item_type rsp_item_ff;

   // Output register can take an item; the row moves when it can or
   // when the last cell holds a bubble
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = out_ready || !chain[zmb_pkg::TOTAL_BITS].valid;
   assign req_stall = !advance;

   // Entry of the row: masked codes, empty results
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].done  = 1'b0;
      chain[0].err   = 1'b0;
      chain[0].probe = req_item.probe_code & zmb_pkg::WIDTH_MASK;
      chain[0].zmin  = req_item.box_min_code & zmb_pkg::WIDTH_MASK;
      chain[0].zmax  = req_item.box_max_code & zmb_pkg::WIDTH_MASK;
      chain[0].lit   = '0;
      chain[0].big   = '0;
   end

   // One cell per code bit, top bit first
   for (genvar i = 0; i < zmb_pkg::TOTAL_BITS; i++) begin : g_cell
      zmb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .bit_pos   (zmb_pkg::POS_BITS'(zmb_pkg::TOTAL_BITS - 1 - i)),
         .state_in  (chain[i]),
         .state_out (chain[i+1])
      );
   end

   // Output register
   assign rsp_valid_in = out_ready ? chain[zmb_pkg::TOTAL_BITS].valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_item_ff.lit_max      <= chain[zmb_pkg::TOTAL_BITS].lit;
         rsp_item_ff.big_min      <= chain[zmb_pkg::TOTAL_BITS].big;
         rsp_item_ff.corner_error <= chain[zmb_pkg::TOTAL_BITS].err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sim/zorder_bigmin_litmax_top_tb.sv -----
`timescale 1ns / 1ps

module zorder_bigmin_litmax_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = zmb_pkg::TOTAL_BITS + 16;
   localparam int PHASE_ITEMS  = 190;

   typedef logic [zmb_pkg::CODE_BITS-1:0] code_type;

   // One directed vector; want is only used where known_result is set
   typedef struct {
      zmb_pkg::req_item_type query;
      bit                    known_result;
      zmb_pkg::rsp_item_type want;
   } vector_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   zmb_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   zmb_pkg::rsp_item_type rsp_item;

   zmb_pkg::rsp_item_type pending_q[$];
   zmb_pkg::rsp_item_type oldest;
   vector_type            vectors[$];
   int                    mismatch_count = 0;
   int                    cycle_count    = 0;
   int                    sender_idle_pct   = 0;
   int                    receiver_stall_pct = 0;

   zorder_bigmin_litmax_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Same-dimension bits strictly below position pos
   function automatic code_type lower_same_dim(input int pos);
      code_type m;
      m = '0;
      for (int j = pos - 2; j >= 0; j -= 2) begin
         m[j] = 1'b1;
      end
      return m;
   endfunction

   // BIGMIN / LITMAX scan, most significant bit first
   function automatic zmb_pkg::rsp_item_type bigmin_litmax(input zmb_pkg::req_item_type q);
      code_type              probe, lo, hi, fill, pos_bit;
      logic [2:0]            sel;
      bit                    halt;
      zmb_pkg::rsp_item_type r;
      probe = q.probe_code & zmb_pkg::WIDTH_MASK;
      lo    = q.box_min_code & zmb_pkg::WIDTH_MASK;
      hi    = q.box_max_code & zmb_pkg::WIDTH_MASK;
      r     = '0;
      halt  = 1'b0;
      for (int bp = zmb_pkg::TOTAL_BITS - 1; bp >= 0 && !halt; bp--) begin
         fill    = lower_same_dim(bp);
         pos_bit = code_type'(1) << bp;
         sel     = {probe[bp], lo[bp], hi[bp]};
         case (sel) inside
            zmb_pkg::SEL_001: begin
               // box straddles above the probe: split, keep upper half as BIGMIN
               r.big_min = (lo & ~fill) | pos_bit;
               hi        = (hi & ~pos_bit) | fill;
            end
            zmb_pkg::SEL_010, zmb_pkg::SEL_110: begin
               r.corner_error = 1'b1;
            end
            zmb_pkg::SEL_011: begin
               r.big_min = lo;
               halt      = 1'b1;
            end
            zmb_pkg::SEL_100: begin
               r.lit_max = hi;
               halt      = 1'b1;
            end
            zmb_pkg::SEL_101: begin
               // box straddles below the probe: split, keep lower half as LITMAX
               r.lit_max = (hi & ~pos_bit) | fill;
               lo        = (lo & ~fill) | pos_bit;
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // x into even bits, y into odd bits
   function automatic code_type interleave(input logic [31:0] x, input logic [31:0] y);
      code_type z;
      z = '0;
      for (int i = 0; i < zmb_pkg::COORD_BITS; i++) begin
         z[2*i]   = x[i];
         z[2*i+1] = y[i];
      end
      return z;
   endfunction

   // Mostly well-formed boxes with shared high prefixes so the scan splits deep;
   // probes inside, near, or on a corner, plus some unordered noise.
   function automatic zmb_pkg::req_item_type random_query();
      zmb_pkg::req_item_type q;
      logic [31:0]  keep_x, keep_y, base_x, base_y, xlo, xhi, ylo, yhi, px, py, tmp;
      int           shape;
      shape  = $urandom_range(99);
      keep_x = ~(32'hffff_ffff >> $urandom_range(32));
      keep_y = ~(32'hffff_ffff >> $urandom_range(32));
      base_x = $urandom;
      base_y = $urandom;
      xlo = (base_x & keep_x) | ($urandom & ~keep_x);
      xhi = (base_x & keep_x) | ($urandom & ~keep_x);
      ylo = (base_y & keep_y) | ($urandom & ~keep_y);
      yhi = (base_y & keep_y) | ($urandom & ~keep_y);
      if (xlo > xhi) begin
         tmp = xlo; xlo = xhi; xhi = tmp;
      end
      if (ylo > yhi) begin
         tmp = ylo; ylo = yhi; yhi = tmp;
      end
      // occasional edge-of-space corners
      if ($urandom_range(9) == 0) xlo = '0;
      if ($urandom_range(9) == 0) xhi = '1;
      if ($urandom_range(9) == 0) ylo = '0;
      if ($urandom_range(9) == 0) yhi = '1;
      if (shape < 40) begin
         px = $urandom_range(xhi, xlo);
         py = $urandom_range(yhi, ylo);
      end else if (shape < 80) begin
         px = (base_x & keep_x) | ($urandom & ~keep_x);
         py = (base_y & keep_y) | ($urandom & ~keep_y);
      end else begin
         px = $urandom_range(1) ? xlo : xhi;
         py = $urandom_range(1) ? ylo : yhi;
      end
      q.probe_code   = interleave(px, py);
      q.box_min_code = interleave(xlo, ylo);
      q.box_max_code = interleave(xhi, yhi);
      if (shape >= 90) begin
         q.probe_code   = {$urandom, $urandom};
         q.box_min_code = {$urandom, $urandom};
         q.box_max_code = {$urandom, $urandom};
      end
      return q;
   endfunction

   task automatic add_vector(input code_type probe, input code_type lo, input code_type hi,
                             input bit known, input code_type lit, input code_type big,
                             input logic err);
      vector_type v;
      v.query.probe_code      = probe;
      v.query.box_min_code    = lo;
      v.query.box_max_code    = hi;
      v.known_result          = known;
      v.want.lit_max          = lit;
      v.want.big_min          = big;
      v.want.corner_error     = err;
      vectors.push_back(v);
   endtask

   // Present one item, hold it until taken, then log what should come back
   task automatic send_query(input zmb_pkg::req_item_type q, input bit known,
                             input zmb_pkg::rsp_item_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= q;
      do @(posedge clock); while (req_stall);
      pending_q.push_back(known ? want : bigmin_litmax(q));
   endtask

   task automatic report_mismatch(input string what, input code_type got, input code_type want);
      $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected item lit_max", rsp_item.lit_max, '0);
         end else begin
            oldest = pending_q.pop_front();
            if (rsp_item.lit_max !== oldest.lit_max)
               report_mismatch("lit_max", rsp_item.lit_max, oldest.lit_max);
            if (rsp_item.big_min !== oldest.big_min)
               report_mismatch("big_min", rsp_item.big_min, oldest.big_min);
            if (rsp_item.corner_error !== oldest.corner_error)
               report_mismatch("corner_error", code_type'(rsp_item.corner_error),
                               code_type'(oldest.corner_error));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("zorder_bigmin_litmax_top_tb failed");
         $finish;
      end
   end

   initial begin
      zmb_pkg::rsp_item_type none;
      none = '0;

      // Directed vectors: trivial ones carry their answer, the rest use the predictor
      add_vector('0, '0, '0, 1, '0, '0, 1'b0);
      add_vector('1, '1, '1, 1, '0, '0, 1'b0);
      add_vector('0, '1, '1, 1, '0, '1, 1'b0);
      add_vector('1, '0, '0, 1, '0, '0, 1'b0);
      add_vector('0, '1, '0, 1, '0, '0, 1'b1);
      add_vector('1, '1, '0, 1, '0, '0, 1'b1);
      // corner error only on the last bit
      add_vector('0, 64'h1, '0, 1, '0, '0, 1'b1);
      // early stop hides a later corner error
      add_vector('0, 64'hc000_0000_0000_0000, 64'h8000_0000_0000_0000, 1,
                 '0, 64'hc000_0000_0000_0000, 1'b0);
      add_vector(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, '0, 1, '0, '0, 1'b0);
      // splits above and below the probe, some of them down to the last bit
      add_vector('0, '0, '1, 0, '0, '0, 1'b0);
      add_vector('1, '0, '1, 0, '0, '0, 1'b0);
      add_vector(64'h5555_5555_5555_5555, '0, 64'haaaa_aaaa_aaaa_aaaa, 0, '0, '0, 1'b0);
      add_vector(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '1, 0, '0, '0, 1'b0);
      add_vector(64'h2, 64'h1, 64'h3, 0, '0, '0, 1'b0);
      add_vector(64'h0000_0000_0000_0030, 64'h0000_0000_0000_000c, 64'h0000_0000_0000_00f3,
                 0, '0, '0, 1'b0);
      add_vector(64'h8000_0000_0000_0000, 64'h0000_0000_0000_000f, 64'h7fff_ffff_ffff_fff0,
                 0, '0, '0, 1'b0);
      add_vector(64'h3000_0000_1234_5678, 64'h3000_0000_0000_0000, 64'h3000_0000_ffff_ffff,
                 0, '0, '0, 1'b0);
      add_vector(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef,
                 0, '0, '0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i]) begin
         send_query(vectors[i].query, vectors[i].known_result, vectors[i].want);
      end

      // Random queries over four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_query(random_query(), 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      // Drain, then give the pipeline time to show any stray item
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("zorder_bigmin_litmax_top_tb passed");
      end else begin
         $display("zorder_bigmin_litmax_top_tb failed");
      end
      $finish;
   end

endmodule
